// File: src/pm_pkg.sv
// Shared types and constants for the polynomial multiplier.
// No dependencies.
package pm_pkg;

  localparam int unsigned CoeffW = 32;
  localparam int unsigned PowerW = 6;

  typedef enum logic [1:0] {
    ACT_FIRST  = 2'd0,
    ACT_SECOND = 2'd1,
    ACT_MUL    = 2'd2
  } act_e;

  // per-cell control from the sequencer
  typedef struct packed {
    logic we;
    logic active;
    logic clear;
  } cell_ctl_t;

endpackage

// File: src/pm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/pm_cell.sv
// One multiply-accumulate cell of the product row (transposed FIR form).
// Holds one first-operand coefficient; depends on pm_pkg.
module pm_cell import pm_pkg::*; (
  input  logic              clk_i,
  input  cell_ctl_t         ctl_i,
  input  logic [CoeffW-1:0] din_i,
  input  logic [CoeffW-1:0] x_i,
  input  logic [CoeffW-1:0] acc_i,
  output logic [CoeffW-1:0] acc_o
);

  logic [CoeffW-1:0] coeff_q;
  logic [CoeffW-1:0] acc_q;
  logic [CoeffW-1:0] acc_d;
  logic [CoeffW-1:0] term;

  assign term  = ctl_i.active ? CoeffW'(coeff_q * x_i) : '0;
  assign acc_d = ctl_i.clear ? '0 : term + acc_i;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      coeff_q <= din_i;
    end
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

// File: src/polynomial_multiplier.sv
// Polynomial multiplier top level: operand storage, cell row, product buffer, output queue.
// Depends on pm_pkg, pm_cell and pm_ram.
//
// Append items are taken while the block is idle; the first operand lives in the cell row,
// the second in a RAM. A compute item with trimmed operand lengths A and B runs the second
// operand through the row of MAX_TERMS multiply-accumulate cells, one coefficient per
// cycle, which yields one product term per cycle into a product RAM. The terms up to the
// highest nonzero one, T of them, then leave at one result per cycle while the output is
// not stalled, through a two-deep output queue. With an empty operand the single zero
// result follows directly. The block takes no new item while a compute item is still
// being computed or reading out of the product RAM; results already queued do not
// hold off the next item.
module polynomial_multiplier import pm_pkg::*; #(
  parameter int unsigned MAX_TERMS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         action_i,
  input  logic signed [31:0] coeff_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] coeff_out_o,
  output logic [5:0]         power_o,
  output logic               last_o,
  output logic               zero_product_o
);

  localparam int unsigned CW = $clog2(MAX_TERMS + 1);
  localparam int unsigned AW = $clog2(MAX_TERMS);
  localparam int unsigned PD = 2 * MAX_TERMS - 1;
  localparam int unsigned PW = $clog2(PD);
  localparam int unsigned TW = $clog2(2 * MAX_TERMS);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  typedef struct packed {
    logic [CoeffW-1:0] coeff;
    logic [PowerW-1:0] power;
    logic              last;
    logic              zero;
  } item_t;

  state_e st_q;

  logic [CW-1:0] fcnt_q, scnt_q, ftop_q, stop_q;
  logic [PW-1:0] k_q, lidx_q, s1i_q, s2i_q, rd_q, pend_pow_q;
  logic [TW-1:0] ptop_q;
  logic          idone_q, s1v_q, s2v_q, xv_q;
  logic          pend_q, pend_last_q, pend_zero_q;
  logic          ov_q, sv_q;
  item_t         out_q, skid_q, pend_item;

  logic              in_acc, f_app, s_app, mul_go, zero_op, iss, fin;
  logic              pop, space, issue, issue_last, emit_zero, r_last;
  logic [1:0]        occ;
  logic [CoeffW-1:0] srd, prd, x;
  logic [CoeffW-1:0] acc [MAX_TERMS+1];

  assign in_ready_o = (st_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign f_app      = in_acc && (action_i == ACT_FIRST) && (fcnt_q != CW'(MAX_TERMS));
  assign s_app      = in_acc && (action_i == ACT_SECOND) && (scnt_q != CW'(MAX_TERMS));
  assign mul_go     = in_acc && (action_i == ACT_MUL);
  assign zero_op    = (ftop_q == '0) || (stop_q == '0);

  assign iss = (st_q == ST_CALC) && !idone_q;
  assign fin = s2v_q && (s2i_q == lidx_q);
  assign x   = xv_q ? srd : '0;

  // cell row
  assign acc[MAX_TERMS] = '0;
  for (genvar i = 0; i < MAX_TERMS; i++) begin : g_cell
    cell_ctl_t ctl;
    assign ctl.we     = f_app && (fcnt_q == CW'(i));
    assign ctl.active = CW'(i) < ftop_q;
    assign ctl.clear  = iss && (k_q == '0);
    pm_cell u_cell (
      .clk_i (clk_i),
      .ctl_i (ctl),
      .din_i (coeff_in_i),
      .x_i   (x),
      .acc_i (acc[i+1]),
      .acc_o (acc[i])
    );
  end

  pm_ram #(.WIDTH(CoeffW), .DEPTH(MAX_TERMS)) u_second (
    .clk_i   (clk_i),
    .we_i    (s_app),
    .waddr_i (scnt_q[AW-1:0]),
    .wdata_i (coeff_in_i),
    .raddr_i (k_q[AW-1:0]),
    .rdata_o (srd)
  );

  pm_ram #(.WIDTH(CoeffW), .DEPTH(PD)) u_prod (
    .clk_i   (clk_i),
    .we_i    (s2v_q),
    .waddr_i (s2i_q),
    .wdata_i (acc[0]),
    .raddr_i (rd_q),
    .rdata_o (prd)
  );

  // readout into a two-slot queue (output register plus skid)
  assign emit_zero  = (ptop_q == '0);
  assign r_last     = (TW'(rd_q) + TW'(1)) == ptop_q;
  assign issue_last = emit_zero || r_last;
  assign pop        = ov_q && out_ready_i;
  assign occ        = 2'(ov_q) + 2'(sv_q) + 2'(pend_q);
  assign space      = occ <= (2'(pop) + 2'd1);
  assign issue      = (st_q == ST_EMIT) && space;

  assign pend_item.coeff = pend_zero_q ? '0 : prd;
  assign pend_item.power = PowerW'(pend_pow_q);
  assign pend_item.last  = pend_last_q;
  assign pend_item.zero  = pend_zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      fcnt_q      <= '0;
      scnt_q      <= '0;
      ftop_q      <= '0;
      stop_q      <= '0;
      k_q         <= '0;
      lidx_q      <= '0;
      idone_q     <= 1'b0;
      s1v_q       <= 1'b0;
      s1i_q       <= '0;
      s2v_q       <= 1'b0;
      s2i_q       <= '0;
      xv_q        <= 1'b0;
      ptop_q      <= '0;
      rd_q        <= '0;
      pend_q      <= 1'b0;
      pend_pow_q  <= '0;
      pend_last_q <= 1'b0;
      pend_zero_q <= 1'b0;
    end else begin
      if (f_app) begin
        fcnt_q <= fcnt_q + CW'(1);
        if (coeff_in_i != '0) begin
          ftop_q <= fcnt_q + CW'(1);
        end
      end
      if (s_app) begin
        scnt_q <= scnt_q + CW'(1);
        if (coeff_in_i != '0) begin
          stop_q <= scnt_q + CW'(1);
        end
      end

      s1v_q <= iss;
      s1i_q <= k_q;
      xv_q  <= iss && (TW'(k_q) < TW'(stop_q));
      s2v_q <= s1v_q;
      s2i_q <= s1i_q;

      if (s2v_q && (acc[0] != '0)) begin
        ptop_q <= TW'(s2i_q) + TW'(1);
      end

      pend_q      <= issue;
      pend_pow_q  <= rd_q;
      pend_last_q <= issue_last;
      pend_zero_q <= emit_zero;

      case (st_q)
        ST_IDLE: begin
          if (mul_go) begin
            ptop_q <= '0;
            rd_q   <= '0;
            if (zero_op) begin
              st_q   <= ST_EMIT;
              fcnt_q <= '0;
              scnt_q <= '0;
              ftop_q <= '0;
              stop_q <= '0;
            end else begin
              st_q    <= ST_CALC;
              k_q     <= '0;
              idone_q <= 1'b0;
              lidx_q  <= PW'(TW'(ftop_q) + TW'(stop_q) - TW'(2));
            end
          end
        end
        ST_CALC: begin
          if (iss) begin
            k_q <= k_q + PW'(1);
            if (k_q == lidx_q) begin
              idone_q <= 1'b1;
            end
          end
          if (fin) begin
            st_q   <= ST_EMIT;
            fcnt_q <= '0;
            scnt_q <= '0;
            ftop_q <= '0;
            stop_q <= '0;
          end
        end
        ST_EMIT: begin
          if (issue) begin
            rd_q <= rd_q + PW'(1);
            if (issue_last) begin
              st_q <= ST_IDLE;
            end
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  // output queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else if (!ov_q || pop) begin
      if (sv_q) begin
        ov_q <= 1'b1;
        sv_q <= pend_q;
      end else begin
        ov_q <= pend_q;
      end
    end else if (pend_q) begin
      sv_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!ov_q || pop) begin
      if (sv_q) begin
        out_q <= skid_q;
        if (pend_q) begin
          skid_q <= pend_item;
        end
      end else if (pend_q) begin
        out_q <= pend_item;
      end
    end else if (pend_q) begin
      skid_q <= pend_item;
    end
  end

  assign out_valid_o    = ov_q;
  assign coeff_out_o    = out_q.coeff;
  assign power_o        = out_q.power;
  assign last_o         = out_q.last;
  assign zero_product_o = out_q.zero;

endmodule

// File: src/pm_chk.sv
// Port-level checker for the polynomial multiplier, bound to the top level.
// Depends on pm_pkg and polynomial_multiplier.
module pm_chk import pm_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [1:0]         action_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] coeff_out_o,
  input logic [5:0]         power_o,
  input logic               last_o,
  input logic               zero_product_o
);

  logic [PowerW-1:0] exp_q;

  // expected power of the next result item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      exp_q <= last_o ? '0 : exp_q + PowerW'(1);
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(coeff_out_o) &&
      $stable(power_o) && $stable(last_o) && $stable(zero_product_o))
    else $error("result item changed while stalled");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_product_o |-> last_o && (power_o == '0) && (coeff_out_o == '0))
    else $error("malformed zero product item");

  a_pow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> power_o == exp_q)
    else $error("product terms out of order");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (action_i == ACT_MUL) |=> !in_ready_o)
    else $error("new item taken while product pending");

endmodule

bind polynomial_multiplier pm_chk u_pm_chk (.*);

// File: bench/polynomial_multiplier_checker.sv
// Checker for the polynomial multiplier: watches both channels, predicts the product terms
// of every compute item and compares each accepted result with the oldest expected term.
// Depends on pm_pkg.
module polynomial_multiplier_checker import pm_pkg::*; #(
  parameter int unsigned MaxTerms = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [1:0]         action_i,
  input  logic signed [31:0] coeff_in_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [31:0] coeff_out_i,
  input  logic [5:0]         power_i,
  input  logic               last_i,
  input  logic               zero_product_i,
  output int                 errors_o,
  output int                 pending_o,
  output int                 terms_o,
  output int                 products_o
);

  typedef struct packed {
    logic [CoeffW-1:0] coeff;
    logic [PowerW-1:0] power;
    logic              last;
    logic              zero;
  } term_t;

  term_t             product_terms[$];
  term_t             seen;
  term_t             want;
  logic [CoeffW-1:0] first_coeffs [MaxTerms];
  logic [CoeffW-1:0] second_coeffs [MaxTerms];
  int unsigned       first_count;
  int unsigned       second_count;
  int unsigned       first_top;
  int unsigned       second_top;
  int                errors = 0;
  int                terms = 0;
  int                products = 0;

  function automatic void push_term(logic [CoeffW-1:0] c, int unsigned p, logic l, logic z);
    term_t t;
    t.coeff = c;
    t.power = PowerW'(p);
    t.last  = l;
    t.zero  = z;
    product_terms.push_back(t);
  endfunction

  // full store drops the item
  function automatic void append_coeff(logic to_second, logic [CoeffW-1:0] v);
    if (!to_second && first_count < MaxTerms) begin
      first_coeffs[first_count] = v;
      first_count++;
      if (v != '0) first_top = first_count;
    end else if (to_second && second_count < MaxTerms) begin
      second_coeffs[second_count] = v;
      second_count++;
      if (v != '0) second_top = second_count;
    end
  endfunction

  function automatic void multiply_operands();
    logic [CoeffW-1:0] acc [2*MaxTerms-1];
    int unsigned       span;
    acc = '{default: '0};
    span = 0;
    products++;
    if (first_top != 0 && second_top != 0) begin
      for (int unsigned i = 0; i < first_top; i++) begin
        for (int unsigned j = 0; j < second_top; j++) begin
          acc[i+j] = acc[i+j] + first_coeffs[i] * second_coeffs[j];
        end
      end
      span = first_top + second_top - 1;
      while (span > 0 && acc[span-1] == '0) span--;
    end
    if (span == 0) begin
      push_term('0, 0, 1'b1, 1'b1);
    end else begin
      for (int unsigned k = 0; k < span; k++) push_term(acc[k], k, k + 1 == span, 1'b0);
    end
    first_count  = 0;
    second_count = 0;
    first_top    = 0;
    second_top   = 0;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      first_count  = 0;
      second_count = 0;
      first_top    = 0;
      second_top   = 0;
      product_terms.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        case (action_i)
          ACT_FIRST:  append_coeff(1'b0, coeff_in_i);
          ACT_SECOND: append_coeff(1'b1, coeff_in_i);
          ACT_MUL:    multiply_operands();
          default:    ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        seen = {coeff_out_i, power_i, last_i, zero_product_i};
        if (product_terms.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected result: coeff %h power %0d last %b zero %b",
                     seen.coeff, seen.power, seen.last, seen.zero);
          end
        end else begin
          want = product_terms.pop_front();
          terms++;
          if (seen.coeff !== want.coeff || seen.power !== want.power ||
              seen.last !== want.last || seen.zero !== want.zero) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: expected coeff %h power %0d last %b zero %b,",
                       want.coeff, want.power, want.last, want.zero,
                       " got coeff %h power %0d last %b zero %b",
                       seen.coeff, seen.power, seen.last, seen.zero);
            end
          end
        end
      end
    end
    pending_o  = product_terms.size();
    errors_o   = errors;
    terms_o    = terms;
    products_o = products;
  end

endmodule

// File: bench/polynomial_multiplier_test.sv
// Testbench top for the polynomial multiplier: clock, reset, operand and compute stimulus
// with bursty input and stalling output, and the final verdict.
// Depends on pm_pkg, polynomial_multiplier and polynomial_multiplier_checker.
module polynomial_multiplier_test import pm_pkg::*; ();

  localparam int unsigned MaxTerms   = 32;
  localparam int unsigned Latency    = 4 * MaxTerms + 16;
  localparam int unsigned CycleLimit = 2_000_000;
  localparam int          ItemTarget = 380;
  localparam logic [1:0]  ActUnused  = 2'd3;

  typedef enum int {RX_OPEN, RX_CHOPPY, RX_SLOW} rx_mode_e;
  typedef logic [31:0] coeff_q_t[$];

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         action;
  logic signed [31:0] coeff_in;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] coeff_out;
  logic [5:0]         power;
  logic               last;
  logic               zero_product;
  int                 errors;
  int                 pending;
  int                 terms;
  int                 products;
  int unsigned        cycles = 0;
  int                 items_sent = 0;
  int                 burst_left = 0;
  rx_mode_e           rx_mode = RX_OPEN;
  int unsigned        rx_left = 0;
  coeff_q_t           empty_op;

  polynomial_multiplier #(.MAX_TERMS(MaxTerms)) u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .action_i       (action),
    .coeff_in_i     (coeff_in),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .coeff_out_o    (coeff_out),
    .power_o        (power),
    .last_o         (last),
    .zero_product_o (zero_product)
  );

  polynomial_multiplier_checker #(.MaxTerms(MaxTerms)) u_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .action_i       (action),
    .coeff_in_i     (coeff_in),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .coeff_out_i    (coeff_out),
    .power_i        (power),
    .last_i         (last),
    .zero_product_i (zero_product),
    .errors_o       (errors),
    .pending_o      (pending),
    .terms_o        (terms),
    .products_o     (products)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("polynomial_multiplier test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 2));
      rx_left <= $urandom_range(20, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_CHOPPY: out_ready <= 1'($urandom_range(0, 1));
      default:   out_ready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  task automatic send_item(logic [1:0] act, logic [31:0] value);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_valid <= 1'b1;
    action   <= act;
    coeff_in <= value;
    do @(posedge clk); while (!in_ready);
    if (act != ActUnused) items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // operands go in interleaved at random, then one compute item
  task automatic multiply_pair(coeff_q_t fa, coeff_q_t sb);
    int i;
    int j;
    i = 0;
    j = 0;
    while (i < fa.size() || j < sb.size()) begin
      if (j >= sb.size() || (i < fa.size() && $urandom_range(0, 1) == 1)) begin
        send_item(ACT_FIRST, fa[i]);
        i++;
      end else begin
        send_item(ACT_SECOND, sb[j]);
        j++;
      end
    end
    send_item(ACT_MUL, $urandom());
  endtask

  function automatic logic [31:0] rand_coeff();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'h8000_0000;
      2:       return 32'h7fff_ffff;
      3:       return '1;
      4:       return 32'(1) << $urandom_range(0, 31);
      5, 6:    return 32'(int'($urandom_range(0, 8)) - 4);
      default: return $urandom();
    endcase
  endfunction

  function automatic int rand_len();
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return $urandom_range(MaxTerms - 2, MaxTerms + 3);
      2, 3:    return $urandom_range(9, MaxTerms);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  // high-power terms are sometimes zero so that trimming is exercised
  function automatic coeff_q_t rand_operand(int n);
    coeff_q_t q;
    int       zeros;
    zeros = (n > 0 && $urandom_range(0, 3) == 0) ? $urandom_range(1, n) : 0;
    for (int k = 0; k < n; k++) q.push_back((k >= n - zeros) ? 32'h0 : rand_coeff());
    return q;
  endfunction

  initial begin
    int seq;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    action   = ACT_FIRST;
    coeff_in = '0;
    seq      = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(ACT_MUL, '0);
    send_item(ActUnused, 32'hffff_ffff);
    multiply_pair('{32'd5}, empty_op);
    multiply_pair('{32'h8000_0000}, '{32'h8000_0000});
    multiply_pair('{32'h7fff_ffff, 32'h0}, '{32'h7fff_ffff, 32'h8000_0000});
    multiply_pair('{32'h0, 32'h0}, '{32'h3});
    multiply_pair('{32'h0, 32'h0, 32'h1}, '{32'h1, 32'h0, 32'hffff_ffff});
    multiply_pair('{32'h0001_0000, 32'h1}, '{32'h0001_0000});
    wait_drained();

    // overfull operand: surplus appends are dropped
    multiply_pair(rand_operand(MaxTerms + 3), rand_operand(MaxTerms));

    while (items_sent < ItemTarget) begin
      case ($urandom_range(0, 9))
        0: send_item(ActUnused, $urandom());
        1: send_item(ACT_MUL, $urandom());
        2: multiply_pair(rand_operand(rand_len()), empty_op);
        3: begin
          repeat ($urandom_range(1, 4)) send_item(2'($urandom_range(0, 1)), rand_coeff());
        end
        default: multiply_pair(rand_operand(rand_len()), rand_operand(rand_len()));
      endcase
      seq++;
      if (seq % 25 == 0) wait_drained();
    end

    wait_drained();
    repeat (Latency) @(posedge clk);
    $display("%0d items sent over %0d sequences; %0d products, %0d result terms checked",
             items_sent, seq, products, terms);
    if (errors == 0 && pending == 0) begin
      $display("polynomial_multiplier test passed");
    end else begin
      $display("polynomial_multiplier test failed");
    end
    $finish;
  end

endmodule

// File: polynomial_multiplier.f
src/pm_pkg.sv
src/pm_ram.sv
src/pm_cell.sv
src/polynomial_multiplier.sv
src/pm_chk.sv
bench/polynomial_multiplier_checker.sv
bench/polynomial_multiplier_test.sv
